// ===== sv/keyed_slot_table_lru_budget_core_macros.svh =====
`ifndef KEYED_SLOT_TABLE_LRU_BUDGET_CORE_MACROS_SVH
`define KEYED_SLOT_TABLE_LRU_BUDGET_CORE_MACROS_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define KSL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, sampled on the block clock, off during reset.
`define KSL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

// ===== sv/ksl_pkg.sv =====
`default_nettype none
package ksl_pkg;

    localparam int MAX_SLOTS_DEF = 32;
    localparam int SIDX_W = 6;
    localparam int KEY_W = 64;
    localparam int HND_W = 32;
    localparam int CELL_W = 5;
    localparam int FB_W = 21;
    localparam int STAMP_W = 32;
    localparam int BYTE_W = 32;
    localparam int SIZE_MAX = 16;
    localparam int BPP_SHIFT = 2;

    typedef logic [SIDX_W-1:0] t_sidx;

    localparam t_sidx NO_SLOT = '1;

    localparam logic [2:0] K_PUT = 3'd0;
    localparam logic [2:0] K_FIND = 3'd1;
    localparam logic [2:0] K_DROP = 3'd2;
    localparam logic [2:0] K_CLEAR = 3'd3;
    localparam logic [2:0] K_GET = 3'd4;

    localparam logic RK_FINAL = 1'b0;
    localparam logic RK_NOTICE = 1'b1;

    localparam logic [2:0] CFG_BUDGET = 3'd0;
    localparam logic [2:0] CFG_CPW = 3'd1;
    localparam logic [2:0] CFG_CPH = 3'd2;
    localparam logic [2:0] CFG_EVICT = 3'd3;

    typedef struct packed {
        logic               mfound;
        t_sidx              midx;
        logic               ffound;
        t_sidx              fidx;
        logic               lfound;
        t_sidx              lidx;
        logic [STAMP_W-1:0] lstamp;
    } t_tok;

    typedef struct packed {
        logic               wr;
        logic               st;
        logic               wipe;
        logic               clr_all;
        t_sidx              idx;
        logic [KEY_W-1:0]   key;
        logic [HND_W-1:0]   handle;
        logic [CELL_W-1:0]  w;
        logic [CELL_W-1:0]  h;
        logic [FB_W-1:0]    fb;
        logic [STAMP_W-1:0] stamp;
    } t_cmd;

    typedef struct packed {
        logic               occ;
        logic [KEY_W-1:0]   key;
        logic [HND_W-1:0]   handle;
        logic [CELL_W-1:0]  w;
        logic [CELL_W-1:0]  h;
        logic [FB_W-1:0]    fb;
    } t_slot;

    typedef struct packed {
        logic               last;
        logic               rk;
        logic [BYTE_W-1:0]  bytes;
        logic [FB_W-1:0]    fb;
        logic [CELL_W-1:0]  h;
        logic [CELL_W-1:0]  w;
        logic [HND_W-1:0]   handle;
        logic [KEY_W-1:0]   key;
        t_sidx              idx;
    } t_res;

    function automatic logic [BYTE_W-1:0] sat_sub(input logic [BYTE_W-1:0] a,
                                                  input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = (a < b) ? '0 : a - b;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/keyed_slot_table_lru_budget_core.sv =====
// Keyed slot table with LRU eviction under a byte budget.
// Input channel (s_t*): one operation per transaction, kind in tuser. Result
// channel (m_t*): notices (tuser 1) followed by one final answer with tlast.
// Config channel (cfg): register index and data, always ready. Config is to be
// written by the user only while idle; the block does not enforce it. The slots
// sit in a row of cells. A scan token walks the row one cell per cycle
// collecting the first key match, the first free slot and the oldest
// evictable slot. The byte cost of a slot comes from a two-stage multiplier.
// Get, rejected puts and unknown kinds present their answer in the cycle after
// the accept. Find answers after one scan; drop after one scan and a cost
// lookup. A put takes one scan and a cost lookup, one more cost lookup when a
// full table evicts a slot, and one more scan and cost lookup for each picture
// evicted to fit the budget. Clear walks the used slots, then wipes every slot.
// The input is taken only while the block is idle and the result register is
// free or being drained. A stalled receiver holds the result register and
// freezes the sequence until it is taken.
// Reset empties every slot and zeroes the counters and configuration.
`default_nettype none
`include "keyed_slot_table_lru_budget_core_macros.svh"
module keyed_slot_table_lru_budget_core #(
    parameter int MAX_SLOTS = ksl_pkg::MAX_SLOTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // content_key, picture_handle, width_cells, height_cells, fallback_code,
    // query_slot, visible_mask
    input  logic [167:0] i_s_tdata,
    // kind
    input  logic [2:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // slot_index, returned_key, returned_handle, slot_width, slot_height,
    // slot_fallback, bytes_in_use
    output logic [167:0] o_m_tdata,
    // result_kind
    output logic [0:0]   o_m_tuser,
    output logic         o_m_tlast,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_SLOTS);
    localparam logic [CW-1:0] SCAN_WAIT = CW'(MAX_SLOTS);
    localparam logic [CW-1:0] COST_WAIT = CW'(2);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_WAIT   = 11'b00000000010,
        S_P_DEC  = 11'b00000000100,
        S_P_BUD  = 11'b00000001000,
        S_P_BEV  = 11'b00000010000,
        S_P_REP  = 11'b00000100000,
        S_P_WR   = 11'b00001000000,
        S_F_DEC  = 11'b00010000000,
        S_D_WIPE = 11'b00100000000,
        S_C_LOOP = 11'b01000000000,
        S_EV_DO  = 11'b10000000000
    } t_state;

    logic [63:0] in_key;
    logic [31:0] in_handle;
    logic [4:0]  in_w;
    logic [4:0]  in_h;
    logic [20:0] in_fb;
    logic [4:0]  in_query;
    logic [31:0] in_mask;

    assign in_key = i_s_tdata[63:0];
    assign in_handle = i_s_tdata[95:64];
    assign in_w = i_s_tdata[100:96];
    assign in_h = i_s_tdata[105:101];
    assign in_fb = i_s_tdata[126:106];
    assign in_query = i_s_tdata[131:127];
    assign in_mask = i_s_tdata[163:132];

    t_state r_state, n_state, r_next, n_next, r_ret, n_ret;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [2:0]  r_kind, n_kind;
    logic [63:0] r_key, n_key;
    logic [31:0] r_handle, n_handle;
    logic [4:0]  r_w, n_w, r_h, n_h, r_cw, n_cw, r_ch, n_ch;
    logic [20:0] r_fb, n_fb;
    logic [31:0] r_mask, n_mask;
    ksl_pkg::t_sidx r_slot, n_slot, r_vslot, n_vslot;
    logic        r_app, n_app;
    logic [31:0] r_want, n_want;
    logic [63:0] r_vkey, n_vkey, r_okey, n_okey;
    logic [31:0] r_vhnd, n_vhnd, r_ohnd, n_ohnd;
    logic        r_oocc, n_oocc;
    logic [CW-1:0] r_used, n_used, r_ci, n_ci;
    logic [31:0] r_clock, n_clock, r_total, n_total;
    logic [31:0] r_budget;
    logic [7:0]  r_cpw, r_cph;
    logic        r_evict;
    logic        r_mv;
    ksl_pkg::t_res r_res;

    ksl_pkg::t_cmd  cmd;
    ksl_pkg::t_tok  tok [MAX_SLOTS+1];
    ksl_pkg::t_slot rd [MAX_SLOTS];
    ksl_pkg::t_tok  tend;
    ksl_pkg::t_slot rs;
    ksl_pkg::t_sidx sel;
    ksl_pkg::t_res  e_res;
    logic           e_valid;
    logic [31:0]    cost;
    logic [31:0]    sub_total;
    logic           out_free;
    logic           s_accept;
    logic           over;
    logic           reject;
    logic [MAX_SLOTS+31:0] mask_ext;

    assign tok[0] = '0;
    assign tend = tok[MAX_SLOTS];
    assign mask_ext = {{MAX_SLOTS{1'b0}}, r_mask};

    for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
        ksl_cell #(.IDX(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_cmd  (cmd),
            .i_key  (r_key),
            .i_vis  (mask_ext[g]),
            .i_live (ksl_pkg::t_sidx'(g) < ksl_pkg::t_sidx'(r_used)),
            .i_tok  (tok[g]),
            .o_tok  (tok[g+1]),
            .o_slot (rd[g])
        );
    end

    ksl_cost u_cost (
        .i_clk (i_clk),
        .i_w   (r_cw),
        .i_h   (r_ch),
        .i_cpw (r_cpw),
        .i_cph (r_cph),
        .o_cost(cost)
    );

    always_comb begin
        case (r_state)
            S_IDLE:            sel = ksl_pkg::t_sidx'({1'b0, in_query});
            S_P_DEC, S_P_BEV:  sel = tend.lidx;
            S_F_DEC:           sel = tend.midx;
            S_C_LOOP:          sel = ksl_pkg::t_sidx'(r_ci);
            default:           sel = r_slot;
        endcase
    end

    assign rs = rd[sel[IW-1:0]];
    assign out_free = !r_mv || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && out_free;
    assign s_accept = i_s_tvalid && o_s_tready;
    assign sub_total = ksl_pkg::sat_sub(r_total, cost);
    assign over = (r_budget != '0) && (r_want != '0)
                  && (({1'b0, r_total} + {1'b0, r_want}) > {1'b0, r_budget});
    assign reject = (in_handle == '0) || (in_w == '0) || (in_h == '0)
                    || (in_w > 5'(ksl_pkg::SIZE_MAX)) || (in_h > 5'(ksl_pkg::SIZE_MAX));

    always_comb begin
        n_state = r_state;
        n_next = r_next;
        n_ret = r_ret;
        n_cnt = r_cnt;
        n_kind = r_kind;
        n_key = r_key;
        n_handle = r_handle;
        n_w = r_w;
        n_h = r_h;
        n_fb = r_fb;
        n_mask = r_mask;
        n_cw = r_cw;
        n_ch = r_ch;
        n_slot = r_slot;
        n_vslot = r_vslot;
        n_app = r_app;
        n_want = r_want;
        n_vkey = r_vkey;
        n_vhnd = r_vhnd;
        n_okey = r_okey;
        n_ohnd = r_ohnd;
        n_oocc = r_oocc;
        n_used = r_used;
        n_ci = r_ci;
        n_clock = r_clock;
        n_total = r_total;
        cmd = '0;
        cmd.idx = ksl_pkg::NO_SLOT;
        e_valid = 1'b0;
        e_res = '0;
        e_res.idx = ksl_pkg::NO_SLOT;
        e_res.bytes = r_total;
        e_res.last = 1'b1;
        e_res.rk = ksl_pkg::RK_FINAL;

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_kind = i_s_tuser;
                    n_key = in_key;
                    n_handle = in_handle;
                    n_w = in_w;
                    n_h = in_h;
                    n_fb = in_fb;
                    n_mask = in_mask;
                    n_cw = in_w;
                    n_ch = in_h;
                    n_app = 1'b0;
                    n_cnt = SCAN_WAIT;
                    case (i_s_tuser)
                        ksl_pkg::K_PUT: begin
                            if (reject) begin
                                e_valid = 1'b1;
                            end else begin
                                n_state = S_WAIT;
                                n_next = S_P_DEC;
                            end
                        end
                        ksl_pkg::K_FIND, ksl_pkg::K_DROP: begin
                            n_state = S_WAIT;
                            n_next = S_F_DEC;
                        end
                        ksl_pkg::K_CLEAR: begin
                            n_ci = '0;
                            n_state = S_C_LOOP;
                        end
                        ksl_pkg::K_GET: begin
                            e_valid = 1'b1;
                            if ((ksl_pkg::t_sidx'({1'b0, in_query})
                                 < ksl_pkg::t_sidx'(r_used)) && rs.occ) begin
                                e_res.idx = sel;
                                e_res.key = rs.key;
                                e_res.handle = rs.handle;
                                e_res.w = rs.w;
                                e_res.h = rs.h;
                                e_res.fb = rs.fb;
                            end
                        end
                        default: begin
                            e_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_WAIT: begin
                if (r_cnt == '0) begin
                    n_state = r_next;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_P_DEC: begin
                n_want = cost;
                if (tend.mfound) begin
                    n_clock = r_clock + 32'd1;
                    cmd.st = 1'b1;
                    cmd.idx = tend.midx;
                    cmd.stamp = r_clock + 32'd1;
                    n_slot = tend.midx;
                    n_state = S_P_BUD;
                end else if (tend.ffound) begin
                    n_slot = tend.fidx;
                    n_state = S_P_BUD;
                end else if (r_used >= MAXC) begin
                    if (r_evict && tend.lfound) begin
                        n_slot = tend.lidx;
                        n_vslot = tend.lidx;
                        n_vkey = rs.key;
                        n_vhnd = rs.handle;
                        n_cw = rs.w;
                        n_ch = rs.h;
                        n_cnt = COST_WAIT;
                        n_next = S_EV_DO;
                        n_ret = S_P_BUD;
                        n_state = S_WAIT;
                    end else if (out_free) begin
                        e_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_slot = ksl_pkg::t_sidx'(r_used);
                    n_used = r_used + 1'b1;
                    n_app = 1'b1;
                    n_state = S_P_BUD;
                end
            end
            S_P_BUD: begin
                if (over) begin
                    n_cnt = SCAN_WAIT;
                    n_next = S_P_BEV;
                    n_state = S_WAIT;
                end else begin
                    n_okey = rs.key;
                    n_ohnd = rs.handle;
                    n_oocc = rs.occ;
                    n_cw = rs.w;
                    n_ch = rs.h;
                    n_cnt = COST_WAIT;
                    n_next = S_P_REP;
                    n_state = S_WAIT;
                end
            end
            S_P_BEV: begin
                if (r_evict && tend.lfound) begin
                    n_vslot = tend.lidx;
                    n_vkey = rs.key;
                    n_vhnd = rs.handle;
                    n_cw = rs.w;
                    n_ch = rs.h;
                    n_cnt = COST_WAIT;
                    n_next = S_EV_DO;
                    n_ret = S_P_BUD;
                    n_state = S_WAIT;
                end else if (out_free) begin
                    if (r_app) begin
                        n_used = r_used - 1'b1;
                    end
                    e_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_EV_DO: begin
                if (out_free) begin
                    n_total = sub_total;
                    cmd.wipe = 1'b1;
                    cmd.idx = r_vslot;
                    e_valid = 1'b1;
                    e_res.rk = ksl_pkg::RK_NOTICE;
                    e_res.last = 1'b0;
                    e_res.idx = r_vslot;
                    e_res.key = r_vkey;
                    e_res.handle = r_vhnd;
                    e_res.bytes = sub_total;
                    n_state = r_ret;
                end
            end
            S_P_REP: begin
                if (out_free) begin
                    if (r_oocc && (r_ohnd != r_handle) && r_evict) begin
                        e_valid = 1'b1;
                        e_res.rk = ksl_pkg::RK_NOTICE;
                        e_res.last = 1'b0;
                        e_res.idx = r_slot;
                        e_res.key = r_okey;
                        e_res.handle = r_ohnd;
                    end
                    n_state = S_P_WR;
                end
            end
            S_P_WR: begin
                if (out_free) begin
                    cmd.wr = 1'b1;
                    cmd.idx = r_slot;
                    cmd.key = r_key;
                    cmd.handle = r_handle;
                    cmd.w = r_w;
                    cmd.h = r_h;
                    cmd.fb = r_fb;
                    cmd.stamp = r_clock + 32'd1;
                    n_clock = r_clock + 32'd1;
                    n_total = sub_total + r_want;
                    e_valid = 1'b1;
                    e_res.idx = r_slot;
                    e_res.bytes = sub_total + r_want;
                    n_state = S_IDLE;
                end
            end
            S_F_DEC: begin
                if (tend.mfound && (r_kind == ksl_pkg::K_DROP)) begin
                    n_clock = r_clock + 32'd1;
                    n_slot = tend.midx;
                    n_cw = rs.w;
                    n_ch = rs.h;
                    n_cnt = COST_WAIT;
                    n_next = S_D_WIPE;
                    n_state = S_WAIT;
                end else if (out_free) begin
                    e_valid = 1'b1;
                    if (tend.mfound) begin
                        n_clock = r_clock + 32'd1;
                        cmd.st = 1'b1;
                        cmd.idx = tend.midx;
                        cmd.stamp = r_clock + 32'd1;
                        e_res.idx = tend.midx;
                    end
                    n_state = S_IDLE;
                end
            end
            S_D_WIPE: begin
                if (out_free) begin
                    n_total = sub_total;
                    cmd.wipe = 1'b1;
                    cmd.idx = r_slot;
                    e_valid = 1'b1;
                    e_res.idx = r_slot;
                    e_res.bytes = sub_total;
                    n_state = S_IDLE;
                end
            end
            S_C_LOOP: begin
                if (out_free) begin
                    if (r_ci < r_used) begin
                        if (r_evict && rs.occ) begin
                            e_valid = 1'b1;
                            e_res.rk = ksl_pkg::RK_NOTICE;
                            e_res.last = 1'b0;
                            e_res.idx = sel;
                            e_res.key = rs.key;
                            e_res.handle = rs.handle;
                        end
                        n_ci = r_ci + 1'b1;
                    end else begin
                        cmd.clr_all = 1'b1;
                        n_used = '0;
                        n_total = '0;
                        e_valid = 1'b1;
                        e_res.bytes = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_next <= S_IDLE;
            r_ret <= S_IDLE;
            r_cnt <= '0;
            r_used <= '0;
            r_ci <= '0;
            r_clock <= '0;
            r_total <= '0;
            r_app <= 1'b0;
            r_budget <= '0;
            r_cpw <= '0;
            r_cph <= '0;
            r_evict <= 1'b0;
            r_mv <= 1'b0;
        end else begin
            r_state <= n_state;
            r_next <= n_next;
            r_ret <= n_ret;
            r_cnt <= n_cnt;
            r_used <= n_used;
            r_ci <= n_ci;
            r_clock <= n_clock;
            r_total <= n_total;
            r_app <= n_app;
            if (e_valid) begin
                r_mv <= 1'b1;
            end else if (i_m_tready) begin
                r_mv <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    ksl_pkg::CFG_BUDGET: r_budget <= i_cfg_data;
                    ksl_pkg::CFG_CPW:    r_cpw <= i_cfg_data[7:0];
                    ksl_pkg::CFG_CPH:    r_cph <= i_cfg_data[7:0];
                    ksl_pkg::CFG_EVICT:  r_evict <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_key <= n_key;
        r_handle <= n_handle;
        r_w <= n_w;
        r_h <= n_h;
        r_fb <= n_fb;
        r_mask <= n_mask;
        r_cw <= n_cw;
        r_ch <= n_ch;
        r_slot <= n_slot;
        r_vslot <= n_vslot;
        r_want <= n_want;
        r_vkey <= n_vkey;
        r_vhnd <= n_vhnd;
        r_okey <= n_okey;
        r_ohnd <= n_ohnd;
        r_oocc <= n_oocc;
        if (e_valid) begin
            r_res <= e_res;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid = r_mv;
    assign o_m_tdata = {3'b000, r_res.bytes, r_res.fb, r_res.h, r_res.w,
                        r_res.handle, r_res.key, r_res.idx};
    assign o_m_tuser = r_res.rk;
    assign o_m_tlast = r_res.last;

    `KSL_ASSERT_NOW(a_used_range, 1'b1, r_used <= MAXC)
    `KSL_ASSERT_NEXT(a_last_ends_item, e_valid && e_res.last, r_state == S_IDLE)
    `KSL_ASSERT_NOW(a_notice_not_last, r_mv && (r_res.rk == ksl_pkg::RK_NOTICE), !r_res.last)
    `KSL_ASSERT_NOW(a_accept_idle_only, s_accept, !r_mv || i_m_tready)

endmodule
`default_nettype wire

// ===== sv/ksl_cell.sv =====
`default_nettype none
module ksl_cell #(
    parameter int IDX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ksl_pkg::t_cmd  i_cmd,
    input  logic [ksl_pkg::KEY_W-1:0] i_key,
    input  logic           i_vis,
    input  logic           i_live,
    input  ksl_pkg::t_tok  i_tok,
    output ksl_pkg::t_tok  o_tok,
    output ksl_pkg::t_slot o_slot
);

    localparam ksl_pkg::t_sidx MY_IDX = ksl_pkg::t_sidx'(IDX);

    logic                             r_valid;
    logic [ksl_pkg::KEY_W-1:0]        r_key;
    logic [ksl_pkg::HND_W-1:0]        r_handle;
    logic [ksl_pkg::CELL_W-1:0]       r_w;
    logic [ksl_pkg::CELL_W-1:0]       r_h;
    logic [ksl_pkg::FB_W-1:0]         r_fb;
    logic [ksl_pkg::STAMP_W-1:0]      r_stamp;
    ksl_pkg::t_tok                    r_tok;
    ksl_pkg::t_tok                    n_tok;
    logic                             hit;
    logic                             cand;

    assign hit = (i_cmd.idx == MY_IDX);
    assign cand = i_live && r_valid && !i_vis;

    always_comb begin
        n_tok = i_tok;
        if (!i_tok.mfound && i_live && r_valid && (r_key == i_key)) begin
            n_tok.mfound = 1'b1;
            n_tok.midx = MY_IDX;
        end
        if (!i_tok.ffound && i_live && !r_valid) begin
            n_tok.ffound = 1'b1;
            n_tok.fidx = MY_IDX;
        end
        if (cand && (!i_tok.lfound || (r_stamp < i_tok.lstamp))) begin
            n_tok.lfound = 1'b1;
            n_tok.lidx = MY_IDX;
            n_tok.lstamp = r_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
            if (i_cmd.clr_all) begin
                r_valid <= 1'b0;
            end else if (hit && i_cmd.wipe) begin
                r_valid <= 1'b0;
            end else if (hit && i_cmd.wr) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (hit && i_cmd.wr) begin
            r_key <= i_cmd.key;
            r_handle <= i_cmd.handle;
            r_w <= i_cmd.w;
            r_h <= i_cmd.h;
            r_fb <= i_cmd.fb;
            r_stamp <= i_cmd.stamp;
        end else if (hit && i_cmd.st) begin
            r_stamp <= i_cmd.stamp;
        end
    end

    assign o_tok = r_tok;
    assign o_slot.occ = r_valid;
    assign o_slot.key = r_valid ? r_key : '0;
    assign o_slot.handle = r_valid ? r_handle : '0;
    assign o_slot.w = r_valid ? r_w : '0;
    assign o_slot.h = r_valid ? r_h : '0;
    assign o_slot.fb = r_valid ? r_fb : '0;

endmodule
`default_nettype wire

// ===== sv/ksl_cost.sv =====
`default_nettype none
module ksl_cost (
    input  logic                         i_clk,
    input  logic [ksl_pkg::CELL_W-1:0]   i_w,
    input  logic [ksl_pkg::CELL_W-1:0]   i_h,
    input  logic [7:0]                   i_cpw,
    input  logic [7:0]                   i_cph,
    output logic [ksl_pkg::BYTE_W-1:0]   o_cost
);

    logic [ksl_pkg::CELL_W+7:0]       r_a;
    logic [ksl_pkg::CELL_W+7:0]       r_b;
    logic [2*(ksl_pkg::CELL_W+8)-1:0] r_c;

    always_ff @(posedge i_clk) begin
        r_a <= i_w * i_cpw;
        r_b <= i_h * i_cph;
        r_c <= r_a * r_b;
    end

    assign o_cost = ksl_pkg::BYTE_W'(r_c) << ksl_pkg::BPP_SHIFT;

endmodule
`default_nettype wire

// ===== verif/tb_keyed_slot_table_lru_budget_core.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_keyed_slot_table_lru_budget_core;

    localparam int SLOTS = 32;

    typedef struct packed {
        logic              rk;
        logic [5:0]        idx;
        logic [63:0]       key;
        logic [31:0]       handle;
        logic [4:0]        w;
        logic [4:0]        h;
        logic [20:0]       fb;
        logic [31:0]       bytes;
        logic              last;
    } t_answer;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [167:0] i_s_tdata;
    logic [2:0]   i_s_tuser;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [167:0] o_m_tdata;
    logic [0:0]   o_m_tuser;
    logic         o_m_tlast;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;

    keyed_slot_table_lru_budget_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser), .o_m_tlast(o_m_tlast),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Shadow copy of the table.
    logic [31:0] budget_reg, cpw_reg, cph_reg;
    logic        evict_reg;
    logic [63:0] tbl_key[SLOTS];
    logic [31:0] tbl_handle[SLOTS];
    logic [4:0]  tbl_w[SLOTS];
    logic [4:0]  tbl_h[SLOTS];
    logic [20:0] tbl_fb[SLOTS];
    logic [31:0] tbl_stamp[SLOTS];
    int          tbl_used;
    logic [31:0] lru_clock;
    logic [31:0] byte_sum;

    t_answer     pending_answers[$];
    int          mismatch_count;
    bit          calm_phase;
    logic [63:0] key_pool[48];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("keyed_slot_table_lru_budget_core regression: fail");
        $finish;
    end

    function automatic logic [63:0] pic_cost(logic [4:0] w, logic [4:0] h);
        if (cpw_reg == 0 || cph_reg == 0) return 64'd0;
        return 64'(w) * 64'(cpw_reg) * 64'(h) * 64'(cph_reg) * 64'd4;
    endfunction

    task automatic take_bytes(logic [63:0] c);
        if (64'(byte_sum) < c) byte_sum = '0;
        else byte_sum = 32'(64'(byte_sum) - c);
    endtask

    task automatic queue_answer(logic rk, logic [5:0] idx, logic [63:0] key,
                                logic [31:0] hd, logic [4:0] w, logic [4:0] h,
                                logic [20:0] fb, logic last);
        t_answer a;
        a = '{rk, idx, key, hd, w, h, fb, byte_sum, last};
        pending_answers.push_back(a);
    endtask

    task automatic empty_slot(int i);
        take_bytes(pic_cost(tbl_w[i], tbl_h[i]));
        tbl_key[i] = '0;
        tbl_handle[i] = '0;
        tbl_w[i] = '0;
        tbl_h[i] = '0;
        tbl_fb[i] = '0;
        tbl_stamp[i] = '0;
    endtask

    task automatic lookup_key(logic [63:0] key, output int slot);
        slot = -1;
        for (int i = 0; i < tbl_used; i++) begin
            if (tbl_handle[i] != 0 && tbl_key[i] == key) begin
                lru_clock++;
                tbl_stamp[i] = lru_clock;
                slot = i;
                break;
            end
        end
    endtask

    task automatic evict_oldest(logic [31:0] mask, output int victim);
        logic [63:0] k;
        logic [31:0] hd;
        victim = -1;
        if (!evict_reg) return;
        for (int i = 0; i < tbl_used; i++) begin
            if (tbl_handle[i] == 0 || mask[i]) continue;
            if (victim < 0 || tbl_stamp[i] < tbl_stamp[victim]) victim = i;
        end
        if (victim < 0) return;
        k = tbl_key[victim];
        hd = tbl_handle[victim];
        empty_slot(victim);
        queue_answer(ksl_pkg::RK_NOTICE, 6'(victim), k, hd, '0, '0, '0, 1'b0);
    endtask

    task automatic predict_put(logic [63:0] key, logic [31:0] hd, logic [4:0] w,
                               logic [4:0] h, logic [20:0] fb, logic [31:0] mask,
                               output int slot);
        bit          appended;
        logic [63:0] want;
        int          v;
        appended = 0;
        slot = -1;
        if (hd == 0 || w < 1 || h < 1 || w > ksl_pkg::SIZE_MAX || h > ksl_pkg::SIZE_MAX)
            return;
        lookup_key(key, slot);
        if (slot < 0) begin
            for (int i = 0; i < tbl_used; i++) begin
                if (tbl_handle[i] == 0) begin
                    slot = i;
                    break;
                end
            end
        end
        if (slot < 0) begin
            if (tbl_used >= SLOTS) begin
                evict_oldest(mask, slot);
                if (slot < 0) return;
            end else begin
                slot = tbl_used;
                tbl_used++;
                appended = 1;
            end
        end
        want = pic_cost(w, h);
        if (budget_reg != 0 && want != 0) begin
            while (64'(byte_sum) + want > 64'(budget_reg)) begin
                evict_oldest(mask, v);
                if (v < 0) begin
                    if (appended) tbl_used--;
                    slot = -1;
                    return;
                end
            end
        end
        if (tbl_handle[slot] != 0 && tbl_handle[slot] != hd && evict_reg)
            queue_answer(ksl_pkg::RK_NOTICE, 6'(slot), tbl_key[slot], tbl_handle[slot],
                         '0, '0, '0, 1'b0);
        take_bytes(pic_cost(tbl_w[slot], tbl_h[slot]));
        tbl_key[slot] = key;
        tbl_handle[slot] = hd;
        tbl_w[slot] = w;
        tbl_h[slot] = h;
        tbl_fb[slot] = fb;
        byte_sum = 32'(64'(byte_sum) + want);
        lru_clock++;
        tbl_stamp[slot] = lru_clock;
    endtask

    task automatic predict_op(logic [2:0] kind, logic [63:0] key, logic [31:0] hd,
                              logic [4:0] w, logic [4:0] h, logic [20:0] fb,
                              logic [4:0] q, logic [31:0] mask);
        int slot;
        case (kind)
            ksl_pkg::K_PUT: begin
                predict_put(key, hd, w, h, fb, mask, slot);
                queue_answer(ksl_pkg::RK_FINAL, 6'(slot), '0, '0, '0, '0, '0, 1'b1);
            end
            ksl_pkg::K_FIND: begin
                lookup_key(key, slot);
                queue_answer(ksl_pkg::RK_FINAL, 6'(slot), '0, '0, '0, '0, '0, 1'b1);
            end
            ksl_pkg::K_DROP: begin
                lookup_key(key, slot);
                if (slot >= 0) empty_slot(slot);
                queue_answer(ksl_pkg::RK_FINAL, 6'(slot), '0, '0, '0, '0, '0, 1'b1);
            end
            ksl_pkg::K_CLEAR: begin
                if (evict_reg)
                    for (int i = 0; i < tbl_used; i++)
                        if (tbl_handle[i] != 0)
                            queue_answer(ksl_pkg::RK_NOTICE, 6'(i), tbl_key[i],
                                         tbl_handle[i], '0, '0, '0, 1'b0);
                for (int i = 0; i < SLOTS; i++) begin
                    tbl_key[i] = '0;
                    tbl_handle[i] = '0;
                    tbl_w[i] = '0;
                    tbl_h[i] = '0;
                    tbl_fb[i] = '0;
                    tbl_stamp[i] = '0;
                end
                tbl_used = 0;
                byte_sum = '0;
                queue_answer(ksl_pkg::RK_FINAL, ksl_pkg::NO_SLOT, '0, '0, '0, '0, '0, 1'b1);
            end
            ksl_pkg::K_GET: begin
                if (int'(q) < tbl_used && tbl_handle[q] != 0)
                    queue_answer(ksl_pkg::RK_FINAL, 6'(q), tbl_key[q], tbl_handle[q],
                                 tbl_w[q], tbl_h[q], tbl_fb[q], 1'b1);
                else
                    queue_answer(ksl_pkg::RK_FINAL, ksl_pkg::NO_SLOT, '0, '0, '0, '0, '0,
                                 1'b1);
            end
            default: queue_answer(ksl_pkg::RK_FINAL, ksl_pkg::NO_SLOT, '0, '0, '0, '0, '0,
                                  1'b1);
        endcase
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: %s mismatch, got %h expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_answer a;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected result", o_m_tdata[63:0], '0);
            end else begin
                a = pending_answers.pop_front();
                if (o_m_tuser[0] !== a.rk) report_mismatch("result_kind", o_m_tuser, a.rk);
                if (o_m_tdata[5:0] !== a.idx) report_mismatch("slot_index", o_m_tdata[5:0], a.idx);
                if (o_m_tdata[69:6] !== a.key) report_mismatch("key", o_m_tdata[69:6], a.key);
                if (o_m_tdata[101:70] !== a.handle)
                    report_mismatch("handle", o_m_tdata[101:70], a.handle);
                if (o_m_tdata[106:102] !== a.w) report_mismatch("width", o_m_tdata[106:102], a.w);
                if (o_m_tdata[111:107] !== a.h) report_mismatch("height", o_m_tdata[111:107], a.h);
                if (o_m_tdata[132:112] !== a.fb)
                    report_mismatch("fallback", o_m_tdata[132:112], a.fb);
                if (o_m_tdata[164:133] !== a.bytes)
                    report_mismatch("bytes_in_use", o_m_tdata[164:133], a.bytes);
                if (o_m_tlast !== a.last) report_mismatch("tlast", o_m_tlast, a.last);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) i_m_tready <= 1'b0;
        else i_m_tready <= calm_phase || ($urandom_range(99) >= 24);
    end

    task automatic send_op(logic [2:0] kind, logic [63:0] key, logic [31:0] hd,
                           logic [4:0] w, logic [4:0] h, logic [20:0] fb,
                           logic [4:0] q, logic [31:0] mask);
        i_s_tvalid <= 1'b1;
        i_s_tuser <= kind;
        i_s_tdata <= {4'b0, mask, q, fb, h, w, hd, key};
        do @(posedge i_clk); while (!o_s_tready);
        predict_op(kind, key, hd, w, h, fb, q, mask);
        if (!calm_phase && $urandom_range(99) < 24) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            ksl_pkg::CFG_BUDGET: budget_reg = value;
            ksl_pkg::CFG_CPW:    cpw_reg = {24'b0, value[7:0]};
            ksl_pkg::CFG_CPH:    cph_reg = {24'b0, value[7:0]};
            ksl_pkg::CFG_EVICT:  evict_reg = value[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_all(logic [31:0] budget, logic [7:0] cpw, logic [7:0] cph,
                           logic ev);
        wait_drained();
        write_reg(ksl_pkg::CFG_BUDGET, budget);
        write_reg(ksl_pkg::CFG_CPW, {24'b0, cpw});
        write_reg(ksl_pkg::CFG_CPH, {24'b0, cph});
        write_reg(ksl_pkg::CFG_EVICT, {31'b0, ev});
    endtask

    task automatic put_op(logic [63:0] key, logic [31:0] hd, logic [4:0] w,
                          logic [4:0] h, logic [31:0] mask);
        send_op(ksl_pkg::K_PUT, key, hd, w, h, 21'($urandom), '0, mask);
    endtask

    task automatic test_rejects_and_lookup();
        send_op(ksl_pkg::K_GET, '0, '0, '0, '0, '0, 5'd0, '0);
        put_op(64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 5'd1, 5'd1, '0);
        put_op(64'h1, 32'h5, 5'd0, 5'd4, '0);
        put_op(64'h1, 32'h5, 5'd17, 5'd4, '0);
        put_op(64'h1, 32'h5, 5'd4, 5'd31, '0);
        send_op(3'd5, 64'h1, 32'h5, 5'd1, 5'd1, '0, '0, '0);
        send_op(3'd7, '1, '1, '1, '1, '1, '1, '1);
        send_op(ksl_pkg::K_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 5'd16, 5'd16,
                21'h10FFFF, 5'd31, '0);
        send_op(ksl_pkg::K_PUT, '0, 32'h1, 5'd1, 5'd1, 21'h0, '0, '0);
        send_op(ksl_pkg::K_FIND, '0, '0, '0, '0, '0, '0, '0);
        send_op(ksl_pkg::K_GET, '0, '0, '0, '0, '0, 5'd0, '0);
        send_op(ksl_pkg::K_GET, '0, '0, '0, '0, '0, 5'd1, '0);
        send_op(ksl_pkg::K_GET, '0, '0, '0, '0, '0, 5'd31, '0);
        send_op(ksl_pkg::K_FIND, 64'h1234, '0, '0, '0, '0, '0, '0);
        put_op('0, 32'h2, 5'd2, 5'd3, '0);
        put_op('0, 32'h2, 5'd3, 5'd2, '0);
        send_op(ksl_pkg::K_DROP, '0, '0, '0, '0, '0, '0, '0);
        send_op(ksl_pkg::K_DROP, '0, '0, '0, '0, '0, '0, '0);
        send_op(ksl_pkg::K_CLEAR, '0, '0, '0, '0, '0, '0, '0);
    endtask

    task automatic test_full_table_eviction();
        set_all(32'd0, 8'd0, 8'd0, 1'b1);
        for (int i = 0; i < SLOTS; i++) put_op(64'(i + 100), 32'(i + 1), 5'd1, 5'd1, '0);
        put_op(64'd999, 32'h77, 5'd2, 5'd2, 32'h0000_0003);
        put_op(64'd998, 32'h78, 5'd2, 5'd2, 32'hFFFF_FFFF);
        send_op(ksl_pkg::K_CLEAR, '0, '0, '0, '0, '0, '0, '0);
    endtask

    task automatic test_byte_budget();
        set_all(32'd4096, 8'd8, 8'd8, 1'b1);
        for (int i = 0; i < 6; i++) put_op(64'(i), 32'(i + 10), 5'd2, 5'd2, '0);
        put_op(64'd50, 32'h99, 5'd4, 5'd4, 32'h1);
        put_op(64'd51, 32'h9A, 5'd16, 5'd16, '0);
        // Growing the cell size makes the recomputed costs exceed the running total.
        set_all(32'd4096, 8'd255, 8'd255, 1'b1);
        send_op(ksl_pkg::K_DROP, 64'd50, '0, '0, '0, '0, '0, '0);
        set_all(32'hFFFF_FFFF, 8'd255, 8'd255, 1'b0);
        put_op(64'd60, 32'h5, 5'd16, 5'd16, '0);
        send_op(ksl_pkg::K_CLEAR, '0, '0, '0, '0, '0, '0, '0);
    endtask

    task automatic random_item();
        int          r;
        logic [63:0] key;
        logic [4:0]  w, h;
        logic [31:0] mask, hd;
        r = $urandom_range(99);
        key = ($urandom_range(9) == 0) ? {$urandom, $urandom} : key_pool[$urandom_range(47)];
        w = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 6));
        h = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 6));
        if ($urandom_range(19) == 0) begin
            w = 5'd16;
            h = 5'd16;
        end
        mask = ($urandom_range(3) == 0) ? $urandom : (32'd1 << $urandom_range(31));
        if ($urandom_range(3) == 0) mask = '0;
        hd = ($urandom_range(19) == 0) ? 32'd0 : ($urandom_range(3) == 0 ? 32'd7 : $urandom);
        if (r < 50)
            send_op(ksl_pkg::K_PUT, key, hd, w, h, 21'($urandom), 5'($urandom), mask);
        else if (r < 64)
            send_op(ksl_pkg::K_FIND, key, $urandom, w, h, 21'($urandom), 5'($urandom), mask);
        else if (r < 75)
            send_op(ksl_pkg::K_DROP, key, $urandom, w, h, 21'($urandom), 5'($urandom), mask);
        else if (r < 77)
            send_op(ksl_pkg::K_CLEAR, key, $urandom, w, h, 21'($urandom), 5'($urandom), mask);
        else if (r < 95)
            send_op(ksl_pkg::K_GET, key, $urandom, w, h, 21'($urandom), 5'($urandom), mask);
        else
            send_op(3'($urandom_range(5, 7)), key, hd, w, h, 21'($urandom), 5'($urandom),
                    mask);
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < 48; i++) key_pool[i] = (i < 40) ? 64'(i) : {$urandom, $urandom};
        set_all(32'd0, 8'd1, 8'd1, 1'b1);
        repeat (30) random_item();
        calm_phase = 1'b1;
        set_all(32'd2000, 8'd4, 8'd4, 1'b1);
        repeat (25) random_item();
        calm_phase = 1'b0;
        set_all(32'd600, 8'd3, 8'd5, 1'b0);
        repeat (20) random_item();
        set_all($urandom_range(400, 5000), 8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)),
                1'b1);
        repeat (25) random_item();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        calm_phase = 1'b0;
        mismatch_count = 0;
        budget_reg = '0;
        cpw_reg = '0;
        cph_reg = '0;
        evict_reg = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            tbl_key[i] = '0;
            tbl_handle[i] = '0;
            tbl_w[i] = '0;
            tbl_h[i] = '0;
            tbl_fb[i] = '0;
            tbl_stamp[i] = '0;
        end
        tbl_used = 0;
        lru_clock = '0;
        byte_sum = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_rejects_and_lookup();
        test_full_table_eviction();
        test_byte_budget();
        test_random_traffic();
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0 && pending_answers.size() == 0)
            $display("keyed_slot_table_lru_budget_core regression: pass");
        else
            $display("keyed_slot_table_lru_budget_core regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/ksl_pkg.sv
sv/ksl_cell.sv
sv/ksl_cost.sv
sv/keyed_slot_table_lru_budget_core.sv
verif/tb_keyed_slot_table_lru_budget_core.sv
